// File: hw/rtl/ptd_pkg.sv
// Package with the shared types and codes of the periodic task dispatcher.
`default_nettype none
package ptd_pkg;

  localparam int MAX_OUT = 8;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_CREATE  = 3'd1;
  localparam logic [2:0] KIND_SUSPEND = 3'd2;
  localparam logic [2:0] KIND_RESUME  = 3'd3;
  localparam logic [2:0] KIND_DELETE  = 3'd4;

  localparam logic [2:0] ST_DISPATCH = 3'd0;
  localparam logic [2:0] ST_NONE     = 3'd1;
  localparam logic [2:0] ST_CREATED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_OK       = 3'd4;
  localparam logic [2:0] ST_FAIL     = 3'd5;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TICK,
    CELL_CREATE,
    CELL_SUSPEND,
    CELL_RESUME,
    CELL_DELETE,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [7:0]  priority_req;
    logic [15:0] period;
    logic [15:0] first_delay;
    logic [7:0]  target_id;
  } cell_ctl_t;

  typedef struct packed {
    logic [7:0]  priority_val;
    logic [15:0] period;
    logic [15:0] countdown;
    logic        live;
    logic        resumed;
  } entry_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_REPORT
  } fsm_t;

endpackage
`default_nettype wire

// File: hw/rtl/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: control sequencer, output register and cell row.
// The input channel takes one command word per accept: tick, create, suspend, resume or
// delete. The result channel returns the words caused by it, the final one marked by last.
// Create, suspend, resume, delete and unknown kinds produce one word, loaded into the output
// register in the accept cycle and visible in the next cycle.
// A tick updates each occupied slot's countdown in its accept cycle and marks the due slots.
// The marks then move one slot per cycle toward slot zero, which feeds the output register,
// unless a stalled receiver holds a mark in slot zero. At most 8 dispatch words are sent
// per tick. A tick with nothing due sends a single none word.
// The report shift is the part that sets the tick time.
// The input side is ready only while no tick report is running and the output register is
// free or being emptied. A stalled receiver holds the output word and any mark in slot zero.
// Synchronous reset empties the table and the output register.
`default_nettype none
module periodic_task_dispatcher #(
  parameter int TASK_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_priority_req,
  input  wire logic [15:0] in_period,
  input  wire logic [15:0] in_first_delay,
  input  wire logic [7:0]  in_target_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [2:0]       out_task_id_out,
  output logic             out_last
);

  localparam int IDW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CW  = $clog2(TASK_COUNT + 1);
  localparam int EW  = $clog2(ptd_pkg::MAX_OUT);

  ptd_pkg::fsm_t      state_r;
  ptd_pkg::fsm_t      state_nxt;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [EW-1:0]      emit_cnt_r;
  logic [EW-1:0]      emit_cnt_nxt;
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [2:0]         out_id_r;
  logic               out_last_r;
  logic               out_load;
  logic [2:0]         out_status_nxt;
  logic [2:0]         out_id_nxt;
  logic               out_last_nxt;
  logic               out_free;
  logic               in_fire;
  logic               is_full;
  logic               found;
  logic               rem;
  logic               rep_last;
  logic [IDW+2:0]     rep_id_ext;
  logic [IDW+2:0]     new_id_ext;
  ptd_pkg::cell_ctl_t ctl;

  logic [TASK_COUNT-1:0]           occ;
  logic [TASK_COUNT-1:0]           after_v;
  logic [TASK_COUNT-1:0]           match_v;
  logic [TASK_COUNT-1:0]           rep_v;
  logic [TASK_COUNT-1:0][IDW-1:0]  ident_v;
  logic [TASK_COUNT-1:0][IDW-1:0]  rep_id_v;
  ptd_pkg::entry_t [TASK_COUNT-1:0] entry_v;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ptd_pkg::FSM_IDLE) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign is_full    = (count_r == CW'(TASK_COUNT));
  assign found      = |match_v;
  assign rem        = |(rep_v >> 1);
  assign rep_last   = !rem || (emit_cnt_r == EW'(ptd_pkg::MAX_OUT - 1));
  assign rep_id_ext = {3'b000, rep_id_v[0]};
  assign new_id_ext = {3'b000, count_r[IDW-1:0]};

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_task_id_out = out_id_r;
  assign out_last        = out_last_r;

  genvar g;
  generate
    for (g = 0; g < TASK_COUNT; g++) begin : g_cell
      logic               after_left;
      ptd_pkg::entry_t    left_entry;
      logic [IDW-1:0]     left_ident;
      logic               right_rep_v;
      logic [IDW-1:0]     right_rep_id;

      assign occ[g] = (count_r > CW'(g));

      if (g == 0) begin : g_first
        assign after_left = 1'b0;
        assign left_entry = '0;
        assign left_ident = '0;
      end else begin : g_mid
        assign after_left = after_v[g-1];
        assign left_entry = entry_v[g-1];
        assign left_ident = ident_v[g-1];
      end

      if (g == TASK_COUNT - 1) begin : g_last
        assign right_rep_v  = 1'b0;
        assign right_rep_id = '0;
      end else begin : g_inner
        assign right_rep_v  = rep_v[g+1];
        assign right_rep_id = rep_id_v[g+1];
      end

      ptd_cell #(
        .IDW(IDW)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .occ         (occ[g]),
        .new_ident   (count_r[IDW-1:0]),
        .after_left  (after_left),
        .left_entry  (left_entry),
        .left_ident  (left_ident),
        .right_rep_v (right_rep_v),
        .right_rep_id(right_rep_id),
        .entry_o     (entry_v[g]),
        .ident_o     (ident_v[g]),
        .after_o     (after_v[g]),
        .match_o     (match_v[g]),
        .rep_v_o     (rep_v[g]),
        .rep_id_o    (rep_id_v[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptd_pkg::FSM_IDLE: begin
        if (in_fire && (in_kind == ptd_pkg::KIND_TICK)) begin
          state_nxt = ptd_pkg::FSM_REPORT;
        end
      end
      ptd_pkg::FSM_REPORT: begin
        if (out_free) begin
          if (rep_v[0] && rep_last) begin
            state_nxt = ptd_pkg::FSM_IDLE;
          end else if (!(|rep_v)) begin
            state_nxt = ptd_pkg::FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ptd_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.op           = ptd_pkg::CELL_HOLD;
    ctl.priority_req = in_priority_req;
    ctl.period       = in_period;
    ctl.first_delay  = in_first_delay;
    ctl.target_id    = in_target_id;
    out_load         = 1'b0;
    out_status_nxt   = ptd_pkg::ST_FAIL;
    out_id_nxt       = 3'd0;
    out_last_nxt     = 1'b1;
    count_nxt        = count_r;
    emit_cnt_nxt     = emit_cnt_r;
    case (state_r)
      ptd_pkg::FSM_IDLE: begin
        emit_cnt_nxt = '0;
        if (in_fire) begin
          case (in_kind)
            ptd_pkg::KIND_TICK: begin
              ctl.op = ptd_pkg::CELL_TICK;
            end
            ptd_pkg::KIND_CREATE: begin
              out_load = 1'b1;
              if (is_full) begin
                out_status_nxt = ptd_pkg::ST_FULL;
              end else begin
                ctl.op         = ptd_pkg::CELL_CREATE;
                out_status_nxt = ptd_pkg::ST_CREATED;
                out_id_nxt     = new_id_ext[2:0];
                count_nxt      = count_r + CW'(1);
              end
            end
            ptd_pkg::KIND_SUSPEND, ptd_pkg::KIND_RESUME, ptd_pkg::KIND_DELETE: begin
              out_load       = 1'b1;
              out_status_nxt = found ? ptd_pkg::ST_OK : ptd_pkg::ST_FAIL;
              if (in_kind == ptd_pkg::KIND_SUSPEND) begin
                ctl.op = ptd_pkg::CELL_SUSPEND;
              end else if (in_kind == ptd_pkg::KIND_RESUME) begin
                ctl.op = ptd_pkg::CELL_RESUME;
              end else begin
                ctl.op = ptd_pkg::CELL_DELETE;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ptd_pkg::FSM_REPORT: begin
        if (rep_v[0]) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_status_nxt = ptd_pkg::ST_DISPATCH;
            out_id_nxt     = rep_id_ext[2:0];
            out_last_nxt   = rep_last;
            emit_cnt_nxt   = emit_cnt_r + EW'(1);
            ctl.op         = rep_last ? ptd_pkg::CELL_CLEAR : ptd_pkg::CELL_SHIFT;
          end
        end else if (|rep_v) begin
          ctl.op = ptd_pkg::CELL_SHIFT;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = ptd_pkg::ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptd_pkg::FSM_IDLE;
      count_r     <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TASK_COUNT))
    else $error("task count exceeds table size");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_v))
    else $error("two slots hold the same task id");

  a_partial_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ptd_pkg::FSM_REPORT))
    else $error("non-final word outside a tick report");

  a_no_accept_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptd_pkg::FSM_REPORT) |-> !in_fire)
    else $error("command accepted during a tick report");

endmodule
`default_nettype wire

// File: hw/rtl/ptd_cell.sv
// One table slot of the dispatcher: entry storage, insertion shift and report shift.
`default_nettype none
module ptd_cell #(
  parameter int IDW = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptd_pkg::cell_ctl_t ctl,
  input  wire logic               occ,
  input  wire logic [IDW-1:0]     new_ident,
  input  wire logic               after_left,
  input  wire ptd_pkg::entry_t    left_entry,
  input  wire logic [IDW-1:0]     left_ident,
  input  wire logic               right_rep_v,
  input  wire logic [IDW-1:0]     right_rep_id,
  output ptd_pkg::entry_t         entry_o,
  output logic [IDW-1:0]          ident_o,
  output logic                    after_o,
  output logic                    match_o,
  output logic                    rep_v_o,
  output logic [IDW-1:0]          rep_id_o
);

  logic [7:0]     prio_r;
  logic [15:0]    period_r;
  logic [15:0]    cd_r;
  logic [IDW-1:0] ident_r;
  logic           live_r;
  logic           resumed_r;
  logic           rep_v_r;
  logic [IDW-1:0] rep_id_r;
  logic           due;
  logic [7:0]     ident_ext;

  assign ident_ext = {{(8 - IDW){1'b0}}, ident_r};
  assign due       = occ && (cd_r == 16'd0) && live_r && resumed_r;
  assign after_o   = !occ || (prio_r > ctl.priority_req);
  assign match_o   = occ && (ident_ext == ctl.target_id);
  assign ident_o   = ident_r;
  assign rep_v_o   = rep_v_r;
  assign rep_id_o  = rep_id_r;

  assign entry_o.priority_val = prio_r;
  assign entry_o.period       = period_r;
  assign entry_o.countdown    = cd_r;
  assign entry_o.live         = live_r;
  assign entry_o.resumed      = resumed_r;

  always_ff @(posedge clk) begin
    case (ctl.op)
      ptd_pkg::CELL_CREATE: begin
        if (after_left) begin
          prio_r   <= left_entry.priority_val;
          period_r <= left_entry.period;
          cd_r     <= left_entry.countdown;
          ident_r  <= left_ident;
        end else if (after_o) begin
          prio_r   <= ctl.priority_req;
          period_r <= ctl.period;
          cd_r     <= ctl.first_delay;
          ident_r  <= new_ident;
        end
      end
      ptd_pkg::CELL_TICK: begin
        rep_id_r <= ident_r;
        if (occ) begin
          if (cd_r != 16'd0) begin
            cd_r <= cd_r - 16'd1;
          end else if (due) begin
            cd_r <= period_r - 16'd1;
          end
        end
      end
      ptd_pkg::CELL_SHIFT: begin
        rep_id_r <= right_rep_id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= 1'b0;
      resumed_r <= 1'b0;
      rep_v_r   <= 1'b0;
    end else begin
      case (ctl.op)
        ptd_pkg::CELL_CREATE: begin
          if (after_left) begin
            live_r    <= left_entry.live;
            resumed_r <= left_entry.resumed;
          end else if (after_o) begin
            live_r    <= 1'b1;
            resumed_r <= 1'b1;
          end
        end
        ptd_pkg::CELL_TICK: begin
          rep_v_r <= due;
        end
        ptd_pkg::CELL_SUSPEND: begin
          if (match_o) begin
            resumed_r <= 1'b0;
          end
        end
        ptd_pkg::CELL_RESUME: begin
          if (match_o) begin
            resumed_r <= 1'b1;
          end
        end
        ptd_pkg::CELL_DELETE: begin
          if (match_o) begin
            live_r <= 1'b0;
          end
        end
        ptd_pkg::CELL_SHIFT: begin
          rep_v_r <= right_rep_v;
        end
        ptd_pkg::CELL_CLEAR: begin
          rep_v_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: tb/periodic_task_dispatcher_test.sv
// Self-checking testbench for the periodic task dispatcher: directed commands, then random ones.
`timescale 1ns / 100ps
module periodic_task_dispatcher_test;

  localparam int TASKS = 8;
  localparam int RANDOM_COMMANDS = 125;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] id;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  prio;
    logic [15:0] period;
    logic [15:0] delay;
    logic [7:0]  target;
    logic        typed;
    logic [2:0]  exp_status;
    logic [2:0]  exp_id;
  } command_row_t;

  localparam int PLAN_ROWS = 25;

  // Rows with typed = 1 carry their expected word; the others are checked by the schedule model.
  command_row_t plan [PLAN_ROWS] = '{
    '{ptd_pkg::KIND_TICK,    8'd0,   16'd0,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_NONE, 3'd0},
    '{ptd_pkg::KIND_SUSPEND, 8'd0,   16'd0,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_FAIL, 3'd0},
    '{KIND_UNUSED_LO,        8'd0,   16'd0,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_FAIL, 3'd0},
    '{KIND_UNUSED_HI,        8'd255, 16'd65535, 16'd65535, 8'd255, 1'b1, ptd_pkg::ST_FAIL, 3'd0},
    '{ptd_pkg::KIND_CREATE,  8'd128, 16'd3,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_CREATED, 3'd0},
    '{ptd_pkg::KIND_CREATE,  8'd255, 16'd0,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_CREATED, 3'd1},
    '{ptd_pkg::KIND_CREATE,  8'd0,   16'd1,     16'd1,     8'd0,   1'b1, ptd_pkg::ST_CREATED, 3'd2},
    '{ptd_pkg::KIND_CREATE,  8'd128, 16'd65535, 16'd65535, 8'd0,   1'b1, ptd_pkg::ST_CREATED, 3'd3},
    '{ptd_pkg::KIND_TICK,    8'd0,   16'd0,     16'd0,     8'd0,   1'b0, ptd_pkg::ST_NONE, 3'd0},
    '{ptd_pkg::KIND_TICK,    8'd0,   16'd0,     16'd0,     8'd0,   1'b0, ptd_pkg::ST_NONE, 3'd0},
    '{ptd_pkg::KIND_SUSPEND, 8'd0,   16'd0,     16'd0,     8'd2,   1'b1, ptd_pkg::ST_OK,   3'd0},
    '{ptd_pkg::KIND_TICK,    8'd0,   16'd0,     16'd0,     8'd0,   1'b0, ptd_pkg::ST_NONE, 3'd0},
    '{ptd_pkg::KIND_RESUME,  8'd0,   16'd0,     16'd0,     8'd2,   1'b1, ptd_pkg::ST_OK,   3'd0},
    '{ptd_pkg::KIND_DELETE,  8'd0,   16'd0,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_OK,   3'd0},
    '{ptd_pkg::KIND_DELETE,  8'd0,   16'd0,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_OK,   3'd0},
    '{ptd_pkg::KIND_TICK,    8'd0,   16'd0,     16'd0,     8'd0,   1'b0, ptd_pkg::ST_NONE, 3'd0},
    '{ptd_pkg::KIND_SUSPEND, 8'd0,   16'd0,     16'd0,     8'd255, 1'b1, ptd_pkg::ST_FAIL, 3'd0},
    '{ptd_pkg::KIND_CREATE,  8'd1,   16'd2,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_CREATED, 3'd4},
    '{ptd_pkg::KIND_CREATE,  8'd0,   16'd1,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_CREATED, 3'd5},
    '{ptd_pkg::KIND_CREATE,  8'd200, 16'd2,     16'd1,     8'd0,   1'b1, ptd_pkg::ST_CREATED, 3'd6},
    '{ptd_pkg::KIND_CREATE,  8'd128, 16'd1,     16'd0,     8'd0,   1'b1, ptd_pkg::ST_CREATED, 3'd7},
    '{ptd_pkg::KIND_CREATE,  8'd255, 16'd65535, 16'd65535, 8'd0,   1'b1, ptd_pkg::ST_FULL, 3'd0},
    '{ptd_pkg::KIND_TICK,    8'd0,   16'd0,     16'd0,     8'd0,   1'b0, ptd_pkg::ST_NONE, 3'd0},
    '{ptd_pkg::KIND_TICK,    8'd0,   16'd0,     16'd0,     8'd0,   1'b0, ptd_pkg::ST_NONE, 3'd0},
    '{ptd_pkg::KIND_RESUME,  8'd0,   16'd0,     16'd0,     8'd8,   1'b1, ptd_pkg::ST_FAIL, 3'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = ptd_pkg::KIND_TICK;
  logic [7:0]  in_priority_req = 8'd0;
  logic [15:0] in_period = 16'd0;
  logic [15:0] in_first_delay = 16'd0;
  logic [7:0]  in_target_id = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_task_id_out;
  logic        out_last;

  periodic_task_dispatcher #(.TASK_COUNT(TASKS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_priority_req(in_priority_req),
    .in_period(in_period),
    .in_first_delay(in_first_delay),
    .in_target_id(in_target_id),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_task_id_out(out_task_id_out),
    .out_last(out_last)
  );

  always #10 clk = ~clk;

  logic [7:0]  slot_prio [TASKS];
  logic [15:0] slot_period [TASKS];
  logic [15:0] slot_countdown [TASKS];
  logic [7:0]  slot_ident [TASKS];
  logic        slot_live [TASKS];
  logic        slot_resumed [TASKS];
  int          slot_total = 0;

  word_t due_words [$];
  word_t step_words [$];
  int    failures = 0;
  int    words_checked = 0;
  int    busy_ticks = 0;
  int    cycle_count = 0;
  bit    calm = 1'b0;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Schedule model: applies one command to the shadow table and leaves its words in step_words.
  task automatic advance_schedule(input logic [2:0] kind, input logic [7:0] prio,
                                  input logic [15:0] period, input logic [15:0] delay,
                                  input logic [7:0] target);
    int         n;
    int         pos;
    int         hit;
    logic [2:0] ids [ptd_pkg::MAX_OUT];
    step_words.delete();
    n = 0;
    hit = -1;
    if (kind == ptd_pkg::KIND_TICK) begin
      for (int i = 0; i < slot_total; i++) begin
        if (slot_countdown[i] == 16'd0) begin
          if (slot_live[i] && slot_resumed[i]) begin
            slot_countdown[i] = slot_period[i] - 16'd1;
            if (n < ptd_pkg::MAX_OUT) begin
              ids[n] = slot_ident[i][2:0];
              n++;
            end
          end
        end else begin
          slot_countdown[i] = slot_countdown[i] - 16'd1;
        end
      end
      if (n == 0) begin
        step_words.push_back(word_t'{ptd_pkg::ST_NONE, 3'd0, 1'b1});
      end else begin
        busy_ticks++;
        for (int k = 0; k < n; k++) begin
          step_words.push_back(word_t'{ptd_pkg::ST_DISPATCH, ids[k], k == n - 1});
        end
      end
    end else if (kind == ptd_pkg::KIND_CREATE) begin
      if (slot_total >= TASKS) begin
        step_words.push_back(word_t'{ptd_pkg::ST_FULL, 3'd0, 1'b1});
      end else begin
        pos = slot_total;
        while (pos > 0 && slot_prio[pos - 1] > prio) pos--;
        for (int j = slot_total; j > pos; j--) begin
          slot_prio[j] = slot_prio[j - 1];
          slot_period[j] = slot_period[j - 1];
          slot_countdown[j] = slot_countdown[j - 1];
          slot_ident[j] = slot_ident[j - 1];
          slot_live[j] = slot_live[j - 1];
          slot_resumed[j] = slot_resumed[j - 1];
        end
        slot_prio[pos] = prio;
        slot_period[pos] = period;
        slot_countdown[pos] = delay;
        slot_ident[pos] = slot_total[7:0];
        slot_live[pos] = 1'b1;
        slot_resumed[pos] = 1'b1;
        step_words.push_back(word_t'{ptd_pkg::ST_CREATED, slot_total[2:0], 1'b1});
        slot_total++;
      end
    end else if (kind == ptd_pkg::KIND_SUSPEND || kind == ptd_pkg::KIND_RESUME ||
                 kind == ptd_pkg::KIND_DELETE) begin
      for (int i = 0; i < slot_total; i++) begin
        if (hit < 0 && slot_ident[i] == target) hit = i;
      end
      if (hit < 0) begin
        step_words.push_back(word_t'{ptd_pkg::ST_FAIL, 3'd0, 1'b1});
      end else begin
        if (kind == ptd_pkg::KIND_SUSPEND) slot_resumed[hit] = 1'b0;
        else if (kind == ptd_pkg::KIND_RESUME) slot_resumed[hit] = 1'b1;
        else slot_live[hit] = 1'b0;
        step_words.push_back(word_t'{ptd_pkg::ST_OK, 3'd0, 1'b1});
      end
    end else begin
      step_words.push_back(word_t'{ptd_pkg::ST_FAIL, 3'd0, 1'b1});
    end
  endtask

  task automatic issue_command(input command_row_t row);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= row.kind;
    in_priority_req <= row.prio;
    in_period <= row.period;
    in_first_delay <= row.delay;
    in_target_id <= row.target;
    do @(posedge clk); while (!in_ready);
    advance_schedule(row.kind, row.prio, row.period, row.delay, row.target);
    if (row.typed) begin
      due_words.push_back(word_t'{row.exp_status, row.exp_id, 1'b1});
    end else begin
      foreach (step_words[k]) due_words.push_back(step_words[k]);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int    stall;
    word_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (due_words.size() == 0) begin
        $error("unexpected result word: status %0d id %0d last %0d",
               out_status, out_task_id_out, out_last);
        failures++;
      end else begin
        want = due_words.pop_front();
        words_checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          failures++;
        end
        if (out_task_id_out !== want.id) begin
          $error("task_id_out: expected %0d, actual %0d", want.id, out_task_id_out);
          failures++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          failures++;
        end
      end
    end
  end

  initial begin
    command_row_t row;
    int           pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < PLAN_ROWS; r++) issue_command(plan[r]);
    for (int r = 0; r < RANDOM_COMMANDS; r++) begin
      if (r % 40 == 0) calm = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      row.prio = 8'($urandom_range(0, 255));
      row.period = 16'($urandom_range(0, 65535));
      row.delay = 16'($urandom_range(0, 65535));
      row.target = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 9));
      row.typed = 1'b0;
      row.exp_status = ptd_pkg::ST_NONE;
      row.exp_id = 3'd0;
      if (pick < 55) begin
        row.kind = ptd_pkg::KIND_TICK;
      end else if (pick < 70) begin
        row.kind = ptd_pkg::KIND_SUSPEND;
      end else if (pick < 85) begin
        row.kind = ptd_pkg::KIND_RESUME;
      end else if (pick < 90) begin
        row.kind = ptd_pkg::KIND_DELETE;
        row.target = 8'($urandom_range(0, 255));
      end else if (pick < 95) begin
        row.kind = ptd_pkg::KIND_CREATE;
      end else begin
        row.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      end
      issue_command(row);
    end
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (TASKS + 8) @(posedge clk);
    if (due_words.size() != 0) begin
      $error("%0d result words never arrived", due_words.size());
      failures++;
    end
    $display("Sent %0d listed and %0d random commands; %0d result words checked.",
             PLAN_ROWS, RANDOM_COMMANDS, words_checked);
    $display("Ticks that dispatched tasks: %0d; failures: %0d.", busy_ticks, failures);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
